/* hdl/ids_pkg.sv */
package ids_pkg;

    localparam int HEADER_BYTES   = 24;
    localparam int SEG_HDR_BYTES  = 12;
    localparam int MARKER_BYTES   = 2;
    localparam int POSITION_WIDTH = 32;

    typedef logic [POSITION_WIDTH-1:0] pos_t;
    typedef logic [POSITION_WIDTH:0]   pos_ext_t;

    localparam pos_t POS_MAX          = '1;
    localparam pos_t JFIF_CHECK_POS   = pos_t'(13);
    localparam pos_t LAST_HEADER_POS  = pos_t'(HEADER_BYTES - 1);
    localparam pos_t FIRST_SEG_OFFSET = pos_t'(MARKER_BYTES);

    typedef logic [HEADER_BYTES-1:0][7:0]  window_t;
    typedef logic [SEG_HDR_BYTES-1:0][7:0] slide_t;

    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_SOI  = 8'hD8;
    localparam logic [7:0] BYTE_APP0 = 8'hE0;
    localparam logic [7:0] BYTE_SOF0 = 8'hC0;
    localparam logic [7:0] BYTE_SOF3 = 8'hC3;
    localparam logic [7:0] BYTE_SOF9 = 8'hC9;
    localparam logic [7:0] BYTE_SOFB = 8'hCB;
    localparam logic [7:0] BYTE_PNG  = 8'h89;
    localparam logic [7:0] BYTE_SUB  = 8'h1A;
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] CHAR_D    = 8'h44;
    localparam logic [7:0] CHAR_F    = 8'h46;
    localparam logic [7:0] CHAR_G    = 8'h47;
    localparam logic [7:0] CHAR_H    = 8'h48;
    localparam logic [7:0] CHAR_I    = 8'h49;
    localparam logic [7:0] CHAR_J    = 8'h4A;
    localparam logic [7:0] CHAR_N    = 8'h4E;
    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_R    = 8'h52;

    typedef enum logic [1:0] {
        FMT_NONE,
        FMT_JPEG,
        FMT_GIF,
        FMT_PNG
    } format_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SEGMENTS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic        found;
        logic [1:0]  image_format;
        logic [31:0] width;
        logic [31:0] height;
    } result_t;

    function automatic logic is_sof(input logic [7:0] m);
        return ((m >= BYTE_SOF0) && (m <= BYTE_SOF3)) ||
               ((m >= BYTE_SOF9) && (m <= BYTE_SOFB));
    endfunction

endpackage

/* hdl/image_dimension_sniffer.sv */
// Reads the bytes of one image file, one beat per byte with the final byte
// marked, and returns one result beat per file: found, format (JPEG, GIF,
// PNG or none) and width and height. A JFIF JPEG is followed segment by
// segment to its start-of-frame header; GIF and PNG sizes come from the
// fixed header. Files shorter than 24 bytes report not found. The block
// takes one byte per clock cycle; a file's result is loaded into the result
// register when its last byte moves on from the input register. Input
// stalls only while a finished result is still held and the next file's
// last byte is waiting behind it.
module image_dimension_sniffer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  ids_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output ids_pkg::result_t result
);

    logic             held_valid;
    ids_pkg::item_t   held_item;
    logic             advance;
    ids_pkg::window_t window;
    logic             long_enough;
    ids_pkg::result_t result_next;
    logic             result_valid_reg;
    ids_pkg::result_t result_reg;

    assign advance = held_valid
                  && (!held_item.last_byte || !result_valid_reg || result_ready);

    ids_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .take       (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    ids_walk u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (held_item),
        .window      (window),
        .long_enough (long_enough)
    );

    ids_decode u_decode (
        .window      (window),
        .long_enough (long_enough),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance && held_item.last_byte)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && held_item.last_byte)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* hdl/ids_in_stage.sv */
module ids_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  ids_pkg::item_t item,
    input  logic           take,
    output logic           held_valid,
    output ids_pkg::item_t held_item
);

    logic           valid_reg;
    ids_pkg::item_t item_reg;

    assign item_ready = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

endmodule

/* hdl/ids_walk.sv */
module ids_walk (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  ids_pkg::item_t   item,
    output ids_pkg::window_t window,
    output logic             long_enough
);

    ids_pkg::window_t win_reg;
    ids_pkg::window_t win_next;
    ids_pkg::slide_t  slide_reg;
    ids_pkg::slide_t  slide_next;
    ids_pkg::pos_t    pos_reg;
    ids_pkg::pos_t    pos_next;
    ids_pkg::pos_t    off_reg;
    ids_pkg::pos_t    off_next;
    ids_pkg::phase_t  phase_reg;
    ids_pkg::phase_t  phase_next;
    ids_pkg::pos_ext_t target;
    ids_pkg::pos_ext_t seg_sum;
    ids_pkg::pos_t    off_adv;
    logic [15:0]      seg_len;
    logic             jfif_check;
    logic             jfif_ok;
    logic             capture;
    logic             stop;

    always_comb
    begin
        slide_next = {slide_reg[ids_pkg::SEG_HDR_BYTES-2:0], item.data_byte};
        target     = ids_pkg::pos_ext_t'(off_reg)
                   + ids_pkg::pos_ext_t'(ids_pkg::SEG_HDR_BYTES - 1);
        capture    = (phase_reg == ids_pkg::PH_SEGMENTS) && (off_reg != ids_pkg::POS_MAX)
                   && (ids_pkg::pos_ext_t'(pos_reg) == target);
        jfif_check = (phase_reg == ids_pkg::PH_FIRST) && (pos_reg == ids_pkg::JFIF_CHECK_POS);

        win_next = win_reg;
        for (int i = 0; i < ids_pkg::HEADER_BYTES; i++)
        begin
            if (pos_reg == ids_pkg::pos_t'(i))
            begin
                win_next[i] = item.data_byte;
            end
        end
        if (capture)
        begin
            for (int k = 0; k < ids_pkg::SEG_HDR_BYTES; k++)
            begin
                win_next[ids_pkg::MARKER_BYTES + k] = slide_next[ids_pkg::SEG_HDR_BYTES - 1 - k];
            end
        end

        jfif_ok = (win_next[0] == ids_pkg::BYTE_FF) && (win_next[1] == ids_pkg::BYTE_SOI)
               && (win_next[2] == ids_pkg::BYTE_FF) && (win_next[3] == ids_pkg::BYTE_APP0)
               && (win_next[6] == ids_pkg::CHAR_J) && (win_next[7] == ids_pkg::CHAR_F)
               && (win_next[8] == ids_pkg::CHAR_I) && (win_next[9] == ids_pkg::CHAR_F);
        stop    = (win_next[2] != ids_pkg::BYTE_FF) || ids_pkg::is_sof(win_next[3]);

        seg_len = {win_next[4], win_next[5]};
        seg_sum = ids_pkg::pos_ext_t'(off_reg) + ids_pkg::pos_ext_t'(ids_pkg::MARKER_BYTES)
                + ids_pkg::pos_ext_t'(seg_len);
        off_adv = seg_sum[ids_pkg::POSITION_WIDTH] ? ids_pkg::POS_MAX
                : seg_sum[ids_pkg::POSITION_WIDTH-1:0];

        phase_next = phase_reg;
        off_next   = off_reg;
        if (jfif_check)
        begin
            if (jfif_ok)
            begin
                phase_next = ids_pkg::PH_SEGMENTS;
                off_next   = off_adv;
            end
            else
            begin
                phase_next = ids_pkg::PH_DONE;
            end
        end
        else if (capture)
        begin
            if (stop)
            begin
                phase_next = ids_pkg::PH_DONE;
            end
            else
            begin
                off_next = off_adv;
            end
        end

        pos_next = (pos_reg == ids_pkg::POS_MAX) ? pos_reg : pos_reg + ids_pkg::pos_t'(1);

        if (item.last_byte)
        begin
            pos_next   = '0;
            off_next   = ids_pkg::FIRST_SEG_OFFSET;
            phase_next = ids_pkg::PH_FIRST;
        end
    end

    assign window      = win_next;
    assign long_enough = (pos_reg >= ids_pkg::LAST_HEADER_POS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            off_reg   <= ids_pkg::FIRST_SEG_OFFSET;
            phase_reg <= ids_pkg::PH_FIRST;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            off_reg   <= off_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            win_reg   <= win_next;
            slide_reg <= slide_next;
        end
    end

endmodule

/* hdl/ids_decode.sv */
module ids_decode (
    input  ids_pkg::window_t window,
    input  logic             long_enough,
    output ids_pkg::result_t result
);

    logic is_jpeg;
    logic is_gif;
    logic is_png;

    always_comb
    begin
        is_jpeg = (window[0] == ids_pkg::BYTE_FF) && (window[1] == ids_pkg::BYTE_SOI)
               && (window[2] == ids_pkg::BYTE_FF);
        is_gif  = (window[0] == ids_pkg::CHAR_G) && (window[1] == ids_pkg::CHAR_I)
               && (window[2] == ids_pkg::CHAR_F);
        is_png  = (window[0] == ids_pkg::BYTE_PNG) && (window[1] == ids_pkg::CHAR_P)
               && (window[2] == ids_pkg::CHAR_N) && (window[3] == ids_pkg::CHAR_G)
               && (window[4] == ids_pkg::BYTE_CR) && (window[5] == ids_pkg::BYTE_LF)
               && (window[6] == ids_pkg::BYTE_SUB) && (window[7] == ids_pkg::BYTE_LF)
               && (window[12] == ids_pkg::CHAR_I) && (window[13] == ids_pkg::CHAR_H)
               && (window[14] == ids_pkg::CHAR_D) && (window[15] == ids_pkg::CHAR_R);

        result = '0;
        if (long_enough)
        begin
            if (is_jpeg)
            begin
                result.found        = 1'b1;
                result.image_format = ids_pkg::FMT_JPEG;
                result.height       = {16'h0000, window[7], window[8]};
                result.width        = {16'h0000, window[9], window[10]};
            end
            else if (is_gif)
            begin
                result.found        = 1'b1;
                result.image_format = ids_pkg::FMT_GIF;
                result.width        = {16'h0000, window[7], window[6]};
                result.height       = {16'h0000, window[9], window[8]};
            end
            else if (is_png)
            begin
                result.found        = 1'b1;
                result.image_format = ids_pkg::FMT_PNG;
                result.width        = {window[16], window[17], window[18], window[19]};
                result.height       = {window[20], window[21], window[22], window[23]};
            end
        end
    end

endmodule

/* hdl/ids_checker.sv */
module ids_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input ids_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_ready,
    input ids_pkg::result_t result
);

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat dropped or changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with empty result register");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.found == (result.image_format != ids_pkg::FMT_NONE)))
        else $error("found flag disagrees with format");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.found |-> (result.width == '0) && (result.height == '0))
        else $error("nonzero dimensions on a not-found result");

endmodule

bind image_dimension_sniffer ids_checker u_ids_checker (.*);

/* sim/image_dimension_sniffer_tb.sv */
`timescale 1ns / 1ps

module image_dimension_sniffer_tb;

    typedef logic [7:0] file_t [$];

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_BYTES    = 200;
    localparam int RANDOM_FILES    = 4;
    localparam int SOF_HDR_BYTES   = 19;

    localparam longint unsigned POS_LIMIT = (64'd1 << ids_pkg::POSITION_WIDTH) - 64'd1;

    localparam logic [7:0] SOF_CODES [0:6] = '{
        ids_pkg::BYTE_SOF0, ids_pkg::BYTE_SOF0 + 8'd1, ids_pkg::BYTE_SOF0 + 8'd2,
        ids_pkg::BYTE_SOF3, ids_pkg::BYTE_SOF9, ids_pkg::BYTE_SOF9 + 8'd1,
        ids_pkg::BYTE_SOFB
    };
    localparam logic [7:0] OTHER_MARKERS [0:7] = '{
        8'hC4, 8'hC8, 8'hCC, 8'hDB, 8'hDD, 8'hE1, 8'hED, 8'hFE
    };

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    ids_pkg::item_t   item;
    logic             result_valid;
    logic             result_ready;
    ids_pkg::result_t result;

    ids_pkg::result_t dims_due [$];
    int               mismatches;
    int               bytes_sent;
    int               files_sent;
    bit               calm;
    bit               hold_off_req;

    logic [7:0]       hdr_win [ids_pkg::HEADER_BYTES];
    logic [7:0]       recent_bytes [ids_pkg::SEG_HDR_BYTES];
    longint unsigned  next_pos;
    longint unsigned  seg_at;
    ids_pkg::phase_t  walk;

    image_dimension_sniffer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_sniffer();
        foreach (hdr_win[i]) hdr_win[i] = '0;
        foreach (recent_bytes[i]) recent_bytes[i] = '0;
        next_pos = 0;
        seg_at   = 64'(ids_pkg::FIRST_SEG_OFFSET);
        walk     = ids_pkg::PH_FIRST;
    endfunction

    function automatic void skip_segment();
        longint unsigned nxt;
        nxt    = seg_at + 64'd2 + 64'({hdr_win[4], hdr_win[5]});
        seg_at = (nxt > POS_LIMIT) ? POS_LIMIT : nxt;
    endfunction

    function automatic bit frame_marker(input logic [7:0] m);
        return (m >= ids_pkg::BYTE_SOF0 && m <= ids_pkg::BYTE_SOF3) ||
               (m >= ids_pkg::BYTE_SOF9 && m <= ids_pkg::BYTE_SOFB);
    endfunction

    function automatic bit sniff_byte(input ids_pkg::item_t beat,
                                      output ids_pkg::result_t res);
        longint unsigned p;
        logic [7:0]      b;
        p   = next_pos;
        b   = beat.data_byte;
        res = '0;
        if (p < ids_pkg::HEADER_BYTES) hdr_win[p] = b;
        for (int i = 0; i < ids_pkg::SEG_HDR_BYTES - 1; i++)
            recent_bytes[i] = recent_bytes[i + 1];
        recent_bytes[ids_pkg::SEG_HDR_BYTES - 1] = b;

        if (walk == ids_pkg::PH_FIRST && p == 64'(ids_pkg::JFIF_CHECK_POS))
        begin
            if (hdr_win[0] == ids_pkg::BYTE_FF && hdr_win[1] == ids_pkg::BYTE_SOI &&
                hdr_win[2] == ids_pkg::BYTE_FF && hdr_win[3] == ids_pkg::BYTE_APP0 &&
                hdr_win[6] == ids_pkg::CHAR_J && hdr_win[7] == ids_pkg::CHAR_F &&
                hdr_win[8] == ids_pkg::CHAR_I && hdr_win[9] == ids_pkg::CHAR_F)
            begin
                walk = ids_pkg::PH_SEGMENTS;
                skip_segment();
            end
            else
            begin
                walk = ids_pkg::PH_DONE;
            end
        end
        else if (walk == ids_pkg::PH_SEGMENTS && seg_at < POS_LIMIT &&
                 p == seg_at + 64'(ids_pkg::SEG_HDR_BYTES - 1))
        begin
            for (int i = 0; i < ids_pkg::SEG_HDR_BYTES; i++)
                hdr_win[ids_pkg::MARKER_BYTES + i] = recent_bytes[i];
            if (hdr_win[2] != ids_pkg::BYTE_FF || frame_marker(hdr_win[3]))
                walk = ids_pkg::PH_DONE;
            else
                skip_segment();
        end

        if (next_pos < POS_LIMIT) next_pos++;
        if (!beat.last_byte) return 1'b0;

        if (p + 64'd1 >= 64'(ids_pkg::HEADER_BYTES))
        begin
            if (hdr_win[0] == ids_pkg::BYTE_FF && hdr_win[1] == ids_pkg::BYTE_SOI &&
                hdr_win[2] == ids_pkg::BYTE_FF)
            begin
                res.found        = 1'b1;
                res.image_format = ids_pkg::FMT_JPEG;
                res.height       = {16'h0, hdr_win[7], hdr_win[8]};
                res.width        = {16'h0, hdr_win[9], hdr_win[10]};
            end
            else if (hdr_win[0] == ids_pkg::CHAR_G && hdr_win[1] == ids_pkg::CHAR_I &&
                     hdr_win[2] == ids_pkg::CHAR_F)
            begin
                res.found        = 1'b1;
                res.image_format = ids_pkg::FMT_GIF;
                res.width        = {16'h0, hdr_win[7], hdr_win[6]};
                res.height       = {16'h0, hdr_win[9], hdr_win[8]};
            end
            else if (hdr_win[0] == ids_pkg::BYTE_PNG && hdr_win[1] == ids_pkg::CHAR_P &&
                     hdr_win[2] == ids_pkg::CHAR_N && hdr_win[3] == ids_pkg::CHAR_G &&
                     hdr_win[4] == ids_pkg::BYTE_CR && hdr_win[5] == ids_pkg::BYTE_LF &&
                     hdr_win[6] == ids_pkg::BYTE_SUB && hdr_win[7] == ids_pkg::BYTE_LF &&
                     hdr_win[12] == ids_pkg::CHAR_I && hdr_win[13] == ids_pkg::CHAR_H &&
                     hdr_win[14] == ids_pkg::CHAR_D && hdr_win[15] == ids_pkg::CHAR_R)
            begin
                res.found        = 1'b1;
                res.image_format = ids_pkg::FMT_PNG;
                res.width        = {hdr_win[16], hdr_win[17], hdr_win[18], hdr_win[19]};
                res.height       = {hdr_win[20], hdr_win[21], hdr_win[22], hdr_win[23]};
            end
        end
        clear_sniffer();
        return 1'b1;
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic file_t noise_file(input int n);
        file_t q;
        repeat (n) q = {q, 8'($urandom)};
        return q;
    endfunction

    function automatic file_t gif_file(input logic [15:0] w, input logic [15:0] h,
                                       input int extra);
        file_t q;
        q = '{ids_pkg::CHAR_G, ids_pkg::CHAR_I, ids_pkg::CHAR_F, 8'h38, 8'h39, 8'h61,
              w[7:0], w[15:8], h[7:0], h[15:8]};
        while (q.size() < ids_pkg::HEADER_BYTES + extra) q = {q, 8'($urandom)};
        return q;
    endfunction

    function automatic file_t png_file(input logic [31:0] w, input logic [31:0] h,
                                       input int extra);
        file_t q;
        q = '{ids_pkg::BYTE_PNG, ids_pkg::CHAR_P, ids_pkg::CHAR_N, ids_pkg::CHAR_G,
              ids_pkg::BYTE_CR, ids_pkg::BYTE_LF, ids_pkg::BYTE_SUB, ids_pkg::BYTE_LF,
              8'h00, 8'h00, 8'h00, 8'h0D,
              ids_pkg::CHAR_I, ids_pkg::CHAR_H, ids_pkg::CHAR_D, ids_pkg::CHAR_R,
              w[31:24], w[23:16], w[15:8], w[7:0], h[31:24], h[23:16], h[15:8], h[7:0]};
        repeat (9 + extra) q = {q, 8'($urandom)};
        return q;
    endfunction

    function automatic file_t other_jpeg_file(input int n);
        file_t q;
        q = '{ids_pkg::BYTE_FF, ids_pkg::BYTE_SOI, ids_pkg::BYTE_FF, 8'($urandom)};
        while (q.size() < n) q = {q, 8'($urandom)};
        return q;
    endfunction

    // APP0 of 16 bytes, n_segs skipped segments, then a frame header last
    function automatic file_t jfif_file(input logic [15:0] w, input logic [15:0] h,
                                        input int n_segs, input logic [7:0] sof);
        file_t q;
        int    seg_len;
        q = '{ids_pkg::BYTE_FF, ids_pkg::BYTE_SOI, ids_pkg::BYTE_FF, ids_pkg::BYTE_APP0,
              8'h00, 8'h10,
              ids_pkg::CHAR_J, ids_pkg::CHAR_F, ids_pkg::CHAR_I, ids_pkg::CHAR_F, 8'h00};
        repeat (9) q = {q, 8'($urandom)};
        for (int s = 0; s < n_segs; s++)
        begin
            seg_len = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 700)
                                                   : $urandom_range(2, 24);
            q = {q, ids_pkg::BYTE_FF, OTHER_MARKERS[$urandom_range(0, 7)],
                 8'(seg_len >> 8), 8'(seg_len)};
            repeat (seg_len - 2) q = {q, 8'($urandom)};
        end
        q = {q, ids_pkg::BYTE_FF, sof, 8'h00, 8'h11, 8'h08,
             h[15:8], h[7:0], w[15:8], w[7:0]};
        repeat (10) q = {q, 8'($urandom)};
        return q;
    endfunction

    function automatic file_t random_file();
        file_t q;
        int    cut;
        int    idx;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                q = jfif_file(pick16(), pick16(), $urandom_range(0, 3),
                              SOF_CODES[$urandom_range(0, 6)]);
                repeat ($urandom_range(0, 8)) q = {q, 8'($urandom)};
                if ($urandom_range(0, 4) == 0)
                begin
                    cut = $urandom_range(ids_pkg::HEADER_BYTES, q.size());
                    while (q.size() > cut) void'(q.pop_back());
                end
            end
            3:       q = gif_file(pick16(), pick16(), $urandom_range(0, 12));
            4:       q = png_file(pick32(), pick32(), $urandom_range(0, 12));
            5:       q = other_jpeg_file($urandom_range(ids_pkg::HEADER_BYTES, 48));
            6:       q = noise_file($urandom_range(1, ids_pkg::HEADER_BYTES - 1));
            7, 8:
            begin
                case ($urandom_range(0, 2))
                    0:       q = jfif_file(pick16(), pick16(), $urandom_range(0, 2),
                                           SOF_CODES[$urandom_range(0, 6)]);
                    1:       q = gif_file(pick16(), pick16(), $urandom_range(0, 6));
                    default: q = png_file(pick32(), pick32(), $urandom_range(0, 6));
                endcase
                // flip one bit, mostly inside the header window
                idx = $urandom_range(0, 1) ? $urandom_range(0, ids_pkg::HEADER_BYTES - 1)
                                           : $urandom_range(0, q.size() - 1);
                q[idx] = q[idx] ^ 8'(1 << $urandom_range(0, 7));
            end
            default: q = noise_file($urandom_range(1, 60));
        endcase
        return q;
    endfunction

    task automatic send_beat(input ids_pkg::item_t beat);
        ids_pkg::result_t dims;
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat ($urandom_range(0, 18)) @(negedge clk);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= beat;
        do @(posedge clk); while (!item_ready);
        bytes_sent++;
        if (sniff_byte(beat, dims)) dims_due = {dims_due, dims};
    endtask

    task automatic send_file(input file_t q);
        ids_pkg::item_t beat;
        foreach (q[i])
        begin
            beat.data_byte = q[i];
            beat.last_byte = (i == q.size() - 1);
            send_beat(beat);
        end
        files_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (dims_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_short_files();
        file_t q;
        send_file(noise_file(1));
        send_file(noise_file(ids_pkg::HEADER_BYTES - 1));
        q = gif_file(16'h1234, 16'h5678, 0);
        void'(q.pop_back());
        send_file(q);
        drain();
    endtask

    task automatic test_gif_dims();
        send_file(gif_file(16'h0000, 16'h0000, 0));
        send_file(gif_file(16'hFFFF, 16'hFFFF, 5));
        send_file(gif_file(pick16(), pick16(), 3));
        drain();
    endtask

    task automatic test_png_dims();
        send_file(png_file(32'h0000_0000, 32'h0000_0000, 0));
        send_file(png_file(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3));
        send_file(png_file(32'h8000_0001, 32'h7FFF_FFFE, 0));
        drain();
    endtask

    task automatic test_frame_markers();
        file_t q;
        foreach (SOF_CODES[i])
        begin
            q = jfif_file(pick16(), pick16(), i % 2, SOF_CODES[i]);
            q = {q, ids_pkg::BYTE_FF, 8'hD9};
            send_file(q);
        end
        drain();
    endtask

    task automatic test_truncated_segment();
        file_t q;
        int    keep;
        q    = jfif_file(16'h0280, 16'h01E0, 2, ids_pkg::BYTE_SOF0);
        keep = q.size() - SOF_HDR_BYTES + ids_pkg::SEG_HDR_BYTES - 1;
        while (q.size() > keep) void'(q.pop_back());
        send_file(q);
        q    = jfif_file(16'h0400, 16'h0300, 1, ids_pkg::BYTE_SOFB);
        keep = q.size() - SOF_HDR_BYTES + 1;
        while (q.size() > keep) void'(q.pop_back());
        send_file(q);
        drain();
    endtask

    task automatic test_non_jfif();
        file_t q;
        send_file(other_jpeg_file(30));
        // JFIF tag spoiled: dimensions come from the first header as it stands
        q = jfif_file(16'h0100, 16'h0200, 1, ids_pkg::BYTE_SOF0);
        q[9] = 8'h58;
        send_file(q);
        drain();
    endtask

    task automatic test_broken_walk();
        file_t q;
        q = jfif_file(16'h0123, 16'h0456, 1, ids_pkg::BYTE_SOF0);
        q[20] = 8'h00;
        send_file(q);
        drain();
    endtask

    task automatic test_backpressure();
        hold_off_req = 1'b1;
        repeat (10) send_file(gif_file(pick16(), pick16(), $urandom_range(0, 2)));
        drain();
    endtask

    task automatic test_random_mix();
        int bytes_at;
        int files_at;
        bytes_at = bytes_sent;
        files_at = files_sent;
        while (bytes_sent - bytes_at < RANDOM_BYTES || files_sent - files_at < RANDOM_FILES)
            send_file(random_file());
        drain();
    endtask

    task automatic test_calm_tail();
        calm = 1'b1;
        repeat (4) send_file(random_file());
        drain();
    endtask

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    always @(posedge clk)
    begin : result_check
        ids_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (dims_due.size() == 0)
            begin
                note_mismatch("unexpected result", 0, longint'(result.width));
            end
            else
            begin
                want = dims_due.pop_front();
                if (result.found != want.found)
                    note_mismatch("found", longint'(want.found), longint'(result.found));
                if (result.image_format != want.image_format)
                    note_mismatch("image_format", longint'(want.image_format),
                                  longint'(result.image_format));
                if (result.width != want.width)
                    note_mismatch("width", longint'(want.width), longint'(result.width));
                if (result.height != want.height)
                    note_mismatch("height", longint'(want.height), longint'(result.height));
            end
        end
    end

    initial
    begin : result_sink
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
                result_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                result_ready <= 1'b1;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin : main_seq
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        mismatches   = 0;
        bytes_sent   = 0;
        files_sent   = 0;
        calm         = 1'b0;
        hold_off_req = 1'b0;
        clear_sniffer();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_short_files();
        test_gif_dims();
        test_png_dims();
        test_frame_markers();
        test_truncated_segment();
        test_non_jfif();
        test_broken_walk();
        test_backpressure();
        test_random_mix();
        test_calm_tail();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
hdl/ids_pkg.sv
hdl/ids_in_stage.sv
hdl/ids_walk.sv
hdl/ids_decode.sv
hdl/image_dimension_sniffer.sv
hdl/ids_checker.sv
sim/image_dimension_sniffer_tb.sv
